// ===== sv/gaussian_splat_pixel_blend_unit_defines.svh =====
// Assertion macros used by the splat blend back end (gspb_back).
`ifndef GAUSSIAN_SPLAT_PIXEL_BLEND_UNIT_DEFINES_SVH
`define GAUSSIAN_SPLAT_PIXEL_BLEND_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GSPB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gspb assertion failed");

// Next-cycle implication, disabled during reset.
`define GSPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gspb assertion failed");

`endif

// ===== sv/gspb_pkg.sv =====
// Types, constants and the exp table generator for the splat blend unit.
`timescale 1ns / 1ps
package gspb_pkg;

   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [15:0] ALPHA_MAX  = 16'd64881;
   localparam logic [15:0] ALPHA_MIN  = 16'd258;
   localparam logic [16:0] T_MIN      = 17'd7;
   localparam logic [17:0] SUM18_MAX  = 18'h3FFFF;
   localparam logic [23:0] SUM24_MAX  = 24'hFFFFFF;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [15:0] CHAN_MAX   = 16'hFFFF;
   localparam int          QUEUE_DEPTH = 4;
   localparam int          QUEUE_PTR_W = 2;
   localparam logic [4:0]  RECIP_STEPS = 5'd25;

   localparam logic [7:0] CSR_BG_RED   = 8'd0;
   localparam logic [7:0] CSR_BG_GREEN = 8'd1;
   localparam logic [7:0] CSR_BG_BLUE  = 8'd2;
   localparam logic [7:0] CSR_DEPTH_EN = 8'd3;

   // One request as it travels from the front end to the blender.
   typedef struct packed {
      logic        is_end;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [15:0] alpha;
      logic [47:0] color;
      logic [23:0] depth;
   } job_type;

   typedef struct packed {
      logic [15:0] background_red;
      logic [15:0] background_green;
      logic [15:0] background_blue;
      logic        depth_output_enable;
   } cfg_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [23:0] inverse_depth;
      logic [16:0] final_transmittance;
      logic [15:0] contributor_count;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_COL,
      BK_DIVW,
      BK_ACC
   } back_state_type;

   // exp(-16y) in Q1.16 for y in Q.30: Taylor series of exp(-y), then squared four times.
   function automatic logic [16:0] exp_from_y(input logic [63:0] y);
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] rnd;
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * y) >> 30) / 64'(k);
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int k = 0; k < 4; k++) begin
         sum = (sum * sum) >> 30;
      end
      rnd = (sum * 64'd65536 + (64'd1 << 29)) >> 30;
      return rnd[16:0];
   endfunction

endpackage

// ===== sv/gspb_recip.sv =====
// Bit-serial reciprocal unit: 2^24 / depth, saturated to 24 bits.
`timescale 1ns / 1ps
module gspb_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] divisor,
   output logic        busy,
   output logic [23:0] quotient
);

   logic [23:0] d_ff;
   logic [24:0] rem_ff;
   logic [24:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic [24:0] rem_sh;
   logic        fits;

   // The numerator is a single one at bit 24, shifted in on the first step.
   assign rem_sh = {rem_ff[23:0], (cnt_ff == gspb_pkg::RECIP_STEPS)};
   assign fits   = rem_sh >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= gspb_pkg::RECIP_STEPS;
      end else if (cnt_ff != 5'd0) begin
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff   <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cnt_ff != 5'd0) begin
         rem_ff <= fits ? (rem_sh - {1'b0, d_ff}) : rem_sh;
         quo_ff <= {quo_ff[23:0], fits};
      end
   end

   assign busy     = cnt_ff != 5'd0;
   assign quotient = (d_ff == 24'd0 || quo_ff[24]) ? gspb_pkg::SUM24_MAX : quo_ff[23:0];

endmodule

// ===== sv/gspb_front.sv =====
// Front end: conic power, exp lookup and alpha, dropping splats that cannot contribute.
`timescale 1ns / 1ps
module gspb_front #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_action,
   input  logic [11:0]           req_pixel_x,
   input  logic [11:0]           req_pixel_y,
   input  logic signed [16:0]    req_mean_x,
   input  logic signed [16:0]    req_mean_y,
   input  logic signed [23:0]    req_conic_a,
   input  logic signed [23:0]    req_conic_b,
   input  logic signed [23:0]    req_conic_c,
   input  logic [15:0]           req_opacity,
   input  logic [47:0]           req_packed_color,
   input  logic [23:0]           req_view_depth,
   input  logic                  q_full,
   output logic                  q_push,
   output gspb_pkg::job_type     q_data
);

   localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
   localparam int PROD_W    = 28 + EXP_IDX_W + 1;

   logic [16:0] exp_rom [EXP_TABLE_DEPTH];

   for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [63:0] EXP_Y = (64'(g) << 29) / EXP_TABLE_DEPTH;
      assign exp_rom[g] = gspb_pkg::exp_from_y(EXP_Y);
   end

   // The alpha slot carries the opacity until the last stage replaces it.
   gspb_pkg::job_type pay_ff [1:7];
   logic [7:1] v_ff;
   logic       adv;

   logic signed [17:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [23:0] ca1_ff, cb1_ff, cc1_ff;
   logic signed [41:0] pa2_ff, pb2_ff, pc2_ff;
   logic signed [59:0] qa3_ff, qb3_ff, qc3_ff;
   logic signed [61:0] q4_ff;
   logic [EXP_IDX_W-1:0] idx5_ff;
   logic neg5_ff, big5_ff, neg6_ff, big6_ff, neg7_ff;
   logic [16:0] e6_ff;
   logic [16:0] araw7_ff;
   logic [PROD_W-1:0] idx_prod;
   logic [16:0] e_eff;
   logic [32:0] op_prod;
   logic [15:0] alpha7;
   logic        keep7;
   gspb_pkg::job_type in_job;

   assign keep7    = pay_ff[7].is_end || (!neg7_ff && alpha7 >= gspb_pkg::ALPHA_MIN);
   assign adv      = !(v_ff[7] && keep7 && q_full);
   assign req_full = !adv;
   assign q_push   = v_ff[7] && keep7 && !q_full;

   assign in_job.is_end  = req_action;
   assign in_job.pixel_x = req_pixel_x;
   assign in_job.pixel_y = req_pixel_y;
   assign in_job.alpha   = req_opacity;
   assign in_job.color   = req_packed_color;
   assign in_job.depth   = req_view_depth;

   assign idx_prod = PROD_W'(q4_ff[27:0]) * PROD_W'(EXP_TABLE_DEPTH);
   assign e_eff    = big6_ff ? 17'd0 : e6_ff;
   assign op_prod  = 33'(pay_ff[6].alpha) * 33'(e_eff);
   assign alpha7   = (araw7_ff > 17'(gspb_pkg::ALPHA_MAX)) ? gspb_pkg::ALPHA_MAX
                                                            : araw7_ff[15:0];

   always_comb begin
      q_data       = pay_ff[7];
      q_data.alpha = alpha7;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[6:1], req_push};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pay_ff[1] <= in_job;
         for (int s = 2; s <= 7; s++) begin
            pay_ff[s] <= pay_ff[s-1];
         end
         dx1_ff  <= 18'(req_mean_x) - signed'({2'b00, req_pixel_x, 4'b0000});
         dy1_ff  <= 18'(req_mean_y) - signed'({2'b00, req_pixel_y, 4'b0000});
         ca1_ff  <= req_conic_a;
         cb1_ff  <= req_conic_b;
         cc1_ff  <= req_conic_c;
         pa2_ff  <= 42'(ca1_ff) * 42'(dx1_ff);
         pb2_ff  <= 42'(cb1_ff) * 42'(dx1_ff);
         pc2_ff  <= 42'(cc1_ff) * 42'(dy1_ff);
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         qa3_ff  <= 60'(pa2_ff) * 60'(dx2_ff);
         qb3_ff  <= 60'(pb2_ff) * 60'(dy2_ff);
         qc3_ff  <= 60'(pc2_ff) * 60'(dy2_ff);
         q4_ff   <= 62'(qa3_ff) + 62'(qc3_ff) + (62'(qb3_ff) <<< 1);
         neg5_ff <= q4_ff[61];
         big5_ff <= !q4_ff[61] && (|q4_ff[60:28]);
         idx5_ff <= idx_prod[28 +: EXP_IDX_W];
         e6_ff   <= exp_rom[idx5_ff];
         big6_ff <= big5_ff;
         neg6_ff <= neg5_ff;
         araw7_ff <= op_prod[32:16];
         neg7_ff <= neg6_ff;
      end
   end

endmodule

// ===== sv/gspb_fifo.sv =====
// Short request queue between the front end and the blender.
`timescale 1ns / 1ps
module gspb_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gspb_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output gspb_pkg::job_type pop_data,
   output logic              empty
);

   gspb_pkg::job_type mem [gspb_pkg::QUEUE_DEPTH];
   logic [gspb_pkg::QUEUE_PTR_W-1:0] wr_ff, rd_ff;
   logic [gspb_pkg::QUEUE_PTR_W:0]   cnt_ff;
   logic do_push, do_pop;

   assign full     = cnt_ff == (gspb_pkg::QUEUE_PTR_W + 1)'(gspb_pkg::QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (gspb_pkg::QUEUE_PTR_W + 1)'(do_push)
                          - (gspb_pkg::QUEUE_PTR_W + 1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/gspb_back.sv =====
// Blender: transmittance recurrence, color and inverse depth sums, pixel results.
`timescale 1ns / 1ps
`include "gaussian_splat_pixel_blend_unit_defines.svh"
module gspb_back (
   input  logic              clock,
   input  logic              reset,
   input  gspb_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  gspb_pkg::job_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_pop,
   output gspb_pkg::rsp_type rsp
);

   gspb_pkg::back_state_type state_ff, state_in;

   logic [16:0] t_ff, tt_ff, w_ff;
   logic [17:0] rs_ff, gs_ff, bs_ff;
   logic [23:0] is_ff;
   logic [15:0] cnt_ff;
   logic        sat_ff, de_ff, out_v_ff;
   logic [15:0] a_ff;
   logic [47:0] col_ff;
   logic [16:0] rp_ff, gp_ff, bp_ff;
   logic [24:0] ip_ff;
   gspb_pkg::rsp_type out_ff;

   logic take, load_out, start_div, div_busy;
   logic [23:0] inv;
   logic [33:0] tt_prod;
   logic [32:0] w_prod, rpr, gpr, bpr, bgr, bgg, bgb;
   logic [40:0] ipr;
   logic [18:0] r_sum, g_sum, b_sum, r_fin, g_fin, b_fin;
   logic [24:0] i_sum;

   gspb_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .divisor  (q_data.depth),
      .busy     (div_busy),
      .quotient (inv)
   );

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      take      = 1'b0;
      load_out  = 1'b0;
      start_div = 1'b0;
      unique case (state_ff)
         gspb_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (q_data.is_end) begin
                  if (!out_v_ff || rsp_pop) begin
                     load_out = 1'b1;
                     q_pop    = 1'b1;
                  end
               end else begin
                  q_pop = 1'b1;
                  if (!sat_ff) begin
                     take      = 1'b1;
                     start_div = cfg.depth_output_enable;
                     state_in  = gspb_pkg::BK_MUL;
                  end
               end
            end
         end
         gspb_pkg::BK_MUL: state_in = gspb_pkg::BK_COL;
         gspb_pkg::BK_COL: begin
            state_in = (tt_ff < gspb_pkg::T_MIN) ? gspb_pkg::BK_IDLE : gspb_pkg::BK_DIVW;
         end
         gspb_pkg::BK_DIVW: begin
            if (!de_ff || !div_busy) state_in = gspb_pkg::BK_ACC;
         end
         gspb_pkg::BK_ACC: state_in = gspb_pkg::BK_IDLE;
         default: state_in = gspb_pkg::BK_IDLE;
      endcase
   end

   assign tt_prod = 34'(t_ff) * 34'(gspb_pkg::ONE_Q16 - 17'(a_ff));
   assign w_prod  = 33'(a_ff) * 33'(t_ff);
   assign rpr     = 33'(col_ff[15:0]) * 33'(w_ff);
   assign gpr     = 33'(col_ff[31:16]) * 33'(w_ff);
   assign bpr     = 33'(col_ff[47:32]) * 33'(w_ff);
   assign ipr     = 41'(inv) * 41'(w_ff);
   assign r_sum   = 19'(rs_ff) + 19'(rp_ff);
   assign g_sum   = 19'(gs_ff) + 19'(gp_ff);
   assign b_sum   = 19'(bs_ff) + 19'(bp_ff);
   assign i_sum   = 25'(is_ff) + ip_ff;
   assign bgr     = 33'(t_ff) * 33'(cfg.background_red);
   assign bgg     = 33'(t_ff) * 33'(cfg.background_green);
   assign bgb     = 33'(t_ff) * 33'(cfg.background_blue);
   assign r_fin   = 19'(rs_ff) + 19'(bgr[32:16]);
   assign g_fin   = 19'(gs_ff) + 19'(bgg[32:16]);
   assign b_fin   = 19'(bs_ff) + 19'(bgb[32:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gspb_pkg::BK_IDLE;
         out_v_ff <= 1'b0;
         t_ff     <= gspb_pkg::ONE_Q16;
         rs_ff    <= '0;
         gs_ff    <= '0;
         bs_ff    <= '0;
         is_ff    <= '0;
         cnt_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_v_ff <= 1'b1;
            t_ff     <= gspb_pkg::ONE_Q16;
            rs_ff    <= '0;
            gs_ff    <= '0;
            bs_ff    <= '0;
            is_ff    <= '0;
            cnt_ff   <= '0;
            sat_ff   <= 1'b0;
         end else begin
            if (rsp_pop) out_v_ff <= 1'b0;
            if (state_ff == gspb_pkg::BK_COL && tt_ff < gspb_pkg::T_MIN) sat_ff <= 1'b1;
            if (state_ff == gspb_pkg::BK_ACC) begin
               rs_ff <= r_sum[18] ? gspb_pkg::SUM18_MAX : r_sum[17:0];
               gs_ff <= g_sum[18] ? gspb_pkg::SUM18_MAX : g_sum[17:0];
               bs_ff <= b_sum[18] ? gspb_pkg::SUM18_MAX : b_sum[17:0];
               is_ff <= i_sum[24] ? gspb_pkg::SUM24_MAX : i_sum[23:0];
               t_ff  <= tt_ff;
               if (cnt_ff != gspb_pkg::COUNT_MAX) cnt_ff <= cnt_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_ff   <= q_data.alpha;
         col_ff <= q_data.color;
         de_ff  <= cfg.depth_output_enable;
      end
      if (state_ff == gspb_pkg::BK_MUL) begin
         tt_ff <= tt_prod[32:16];
         w_ff  <= w_prod[32:16];
      end
      if (state_ff == gspb_pkg::BK_COL) begin
         rp_ff <= rpr[32:16];
         gp_ff <= gpr[32:16];
         bp_ff <= bpr[32:16];
      end
      if (state_ff == gspb_pkg::BK_DIVW) begin
         ip_ff <= de_ff ? ipr[40:16] : 25'd0;
      end
      if (load_out) begin
         out_ff.pixel_x             <= q_data.pixel_x;
         out_ff.pixel_y             <= q_data.pixel_y;
         out_ff.red                 <= (r_fin > 19'(gspb_pkg::CHAN_MAX)) ? gspb_pkg::CHAN_MAX
                                                                         : r_fin[15:0];
         out_ff.green               <= (g_fin > 19'(gspb_pkg::CHAN_MAX)) ? gspb_pkg::CHAN_MAX
                                                                         : g_fin[15:0];
         out_ff.blue                <= (b_fin > 19'(gspb_pkg::CHAN_MAX)) ? gspb_pkg::CHAN_MAX
                                                                         : b_fin[15:0];
         out_ff.inverse_depth       <= is_ff;
         out_ff.final_transmittance <= t_ff;
         out_ff.contributor_count   <= cnt_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

   `GSPB_ASSERT_NOW(a_t_bounded, clock, reset, 1'b1, t_ff <= gspb_pkg::ONE_Q16)
   `GSPB_ASSERT_NOW(a_no_acc_when_sat, clock, reset, state_ff == gspb_pkg::BK_ACC, !sat_ff)
   `GSPB_ASSERT_NEXT(a_div_to_acc, clock, reset,
                     state_ff == gspb_pkg::BK_DIVW && de_ff && !div_busy,
                     state_ff == gspb_pkg::BK_ACC)
   `GSPB_ASSERT_NEXT(a_t_falls, clock, reset,
                     state_ff == gspb_pkg::BK_ACC, t_ff <= $past(t_ff))

endmodule

// ===== sv/gaussian_splat_pixel_blend_unit.sv =====
// Top level of the Gaussian splat front-to-back pixel blend unit.
//
// Requests enter through a queue-style port: a request is taken when req_push is
// high and req_full is low. A request with req_action low is one depth-sorted
// splat for the current pixel; with req_action high it closes the pixel and
// produces one result, which waits on the rsp_ ports while rsp_empty is low and
// leaves when rsp_pop is high.
// A seven-stage front end computes the conic power, the exp table lookup and
// alpha, and accepts one request per cycle unless a full queue stalls it;
// splats that cannot contribute are dropped there and never reach the
// blender. A four-entry queue feeds the blender, which takes a contributing
// splat through BK_IDLE, BK_MUL, BK_COL, BK_DIVW and BK_ACC; with inverse depth
// on it waits in BK_DIVW for the bit-serial 2^24/depth reciprocal (25 steps);
// a splat that saturates the pixel leaves after BK_COL, and a splat for a
// saturated pixel or an end request is handled in BK_IDLE alone.
// A full result slot stalls only the closing request; the front end keeps
// filling the queue. Reset empties the pipeline and queue, clears the pixel
// accumulators to transmittance 1.0 and sets the background to black with
// inverse depth enabled. Configuration writes are always accepted.
`timescale 1ns / 1ps
module gaussian_splat_pixel_blend_unit #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [11:0]        req_pixel_x,
   input  logic [11:0]        req_pixel_y,
   input  logic signed [16:0] req_mean_x,
   input  logic signed [16:0] req_mean_y,
   input  logic signed [23:0] req_conic_a,
   input  logic signed [23:0] req_conic_b,
   input  logic signed [23:0] req_conic_c,
   input  logic [15:0]        req_opacity,
   input  logic [47:0]        req_packed_color,
   input  logic [23:0]        req_view_depth,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [11:0]        rsp_out_pixel_x,
   output logic [11:0]        rsp_out_pixel_y,
   output logic [15:0]        rsp_red,
   output logic [15:0]        rsp_green,
   output logic [15:0]        rsp_blue,
   output logic [23:0]        rsp_inverse_depth,
   output logic [16:0]        rsp_final_transmittance,
   output logic [15:0]        rsp_contributor_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   gspb_pkg::cfg_type cfg_ff;
   gspb_pkg::job_type f_data, b_data;
   gspb_pkg::rsp_type rsp;
   logic f_push, q_full, q_empty, q_pop, rsp_valid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.background_red      <= '0;
         cfg_ff.background_green    <= '0;
         cfg_ff.background_blue     <= '0;
         cfg_ff.depth_output_enable <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            gspb_pkg::CSR_BG_RED:   cfg_ff.background_red      <= csr_wdata;
            gspb_pkg::CSR_BG_GREEN: cfg_ff.background_green    <= csr_wdata;
            gspb_pkg::CSR_BG_BLUE:  cfg_ff.background_blue     <= csr_wdata;
            gspb_pkg::CSR_DEPTH_EN: cfg_ff.depth_output_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   gspb_front #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_mean_x       (req_mean_x),
      .req_mean_y       (req_mean_y),
      .req_conic_a      (req_conic_a),
      .req_conic_b      (req_conic_b),
      .req_conic_c      (req_conic_c),
      .req_opacity      (req_opacity),
      .req_packed_color (req_packed_color),
      .req_view_depth   (req_view_depth),
      .q_full           (q_full),
      .q_push           (f_push),
      .q_data           (f_data)
   );

   gspb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (b_data),
      .empty     (q_empty)
   );

   gspb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (b_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_empty               = !rsp_valid;
   assign rsp_out_pixel_x         = rsp.pixel_x;
   assign rsp_out_pixel_y         = rsp.pixel_y;
   assign rsp_red                 = rsp.red;
   assign rsp_green               = rsp.green;
   assign rsp_blue                = rsp.blue;
   assign rsp_inverse_depth       = rsp.inverse_depth;
   assign rsp_final_transmittance = rsp.final_transmittance;
   assign rsp_contributor_count   = rsp.contributor_count;

endmodule
